@@ rtl/rmq_pkg.sv @@
// ----------------------------------------------------------------------------
// rmq_pkg
// shared types for the rotation matrix to quaternion pipeline
// ----------------------------------------------------------------------------
package rmq_pkg;

   typedef enum logic [1:0] {
      PIVOT_W = 2'd0,
      PIVOT_X = 2'd1,
      PIVOT_Y = 2'd2,
      PIVOT_Z = 2'd3
   } pivot_type;

   localparam int PIVOT_WIDTH = 2;

   // pipeline control handed to the arithmetic pipes
   typedef struct packed {
      logic advance;
      logic valid;
   } pipe_ctl_type;

endpackage

@@ rtl/rotation_matrix_to_quaternion.sv @@
// pipeline: stage 1, stage 2, the square root, stage 3, the dividers and the output register;
//   QW = square root digit stages, NW = divider quotient bit stages
// throughput: one item per cycle; the whole pipe holds while a result is stalled
// reset clears the stage valid bits only; payload registers are not reset
// ----------------------------------------------------------------------------
// rotation_matrix_to_quaternion
// pipelined 3x3 rotation matrix to unit quaternion with pivot selection
// ----------------------------------------------------------------------------
module rotation_matrix_to_quaternion #(
   parameter int ELEMENT_WIDTH = 16,
   parameter int FRACTION_BITS = 14
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic signed [ELEMENT_WIDTH-1:0] req_row0_col0,
   input  logic signed [ELEMENT_WIDTH-1:0] req_row0_col1,
   input  logic signed [ELEMENT_WIDTH-1:0] req_row0_col2,
   input  logic signed [ELEMENT_WIDTH-1:0] req_row1_col0,
   input  logic signed [ELEMENT_WIDTH-1:0] req_row1_col1,
   input  logic signed [ELEMENT_WIDTH-1:0] req_row1_col2,
   input  logic signed [ELEMENT_WIDTH-1:0] req_row2_col0,
   input  logic signed [ELEMENT_WIDTH-1:0] req_row2_col1,
   input  logic signed [ELEMENT_WIDTH-1:0] req_row2_col2,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic signed [ELEMENT_WIDTH-1:0] rsp_quat_w,
   output logic signed [ELEMENT_WIDTH-1:0] rsp_quat_x,
   output logic signed [ELEMENT_WIDTH-1:0] rsp_quat_y,
   output logic signed [ELEMENT_WIDTH-1:0] rsp_quat_z,
   output rmq_pkg::pivot_type             rsp_pivot_case,
   output logic                           rsp_saturated
);
   import rmq_pkg::*;

   localparam int W   = ELEMENT_WIDTH;
   localparam int F   = FRACTION_BITS;
   localparam int M   = (W > F) ? W : F;
   localparam int TW  = W + 2;
   localparam int RSW = M + 3;
   localparam int RUW = M + 2;
   localparam int VW  = RUW + F;
   localparam int QW  = (VW + 1) / 2;
   localparam int VEW = 2 * QW;
   localparam int DW  = QW + 1;
   localparam int NW0 = W + 1 + F;
   localparam int NW  = ((NW0 > QW) ? NW0 : QW) + 1;
   localparam int SQS = PIVOT_WIDTH + 3 * (W + 1);
   localparam int D0S = PIVOT_WIDTH + QW + 1;

   localparam logic signed [RSW-1:0] ONE   = RSW'(1) << F;
   localparam logic [NW-1:0]         LIM_N = NW'(1) << (W - 1);
   localparam logic [NW-1:0]         LIM_P = (NW'(1) << (W - 1)) - NW'(1);

   // saturating sign application, returns {sat, value}
   function automatic logic [W:0] clamp_q(input logic [NW-1:0] q, input logic neg);
      logic          sat;
      logic [W-1:0]  val;
      if (neg) begin
         sat = (q > LIM_N);
         val = sat ? {1'b1, {(W-1){1'b0}}} : (~q[W-1:0] + W'(1));
      end else begin
         sat = (q > LIM_P);
         val = sat ? {1'b0, {(W-1){1'b1}}} : q[W-1:0];
      end
      return {sat, val};
   endfunction

   logic         advance;

   assign advance     = !(rsp_valid && rsp_stall);
   assign req_stall   = !advance;

   // stage 1: trace, diagonal compares, off-diagonal sums and differences
   logic                  v1_ff;
   logic signed [TW-1:0]  tr_ff;
   logic signed [W-1:0]   a00_ff, a11_ff, a22_ff;
   logic                  gt0011_ff, gt0022_ff, gt1122_ff;
   logic signed [W:0]     m21_ff, m02_ff, m10_ff, p01_ff, p02_ff, p12_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else if (advance) begin
         v1_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         tr_ff     <= TW'(req_row0_col0) + TW'(req_row1_col1) + TW'(req_row2_col2);
         a00_ff    <= req_row0_col0;
         a11_ff    <= req_row1_col1;
         a22_ff    <= req_row2_col2;
         gt0011_ff <= req_row0_col0 > req_row1_col1;
         gt0022_ff <= req_row0_col0 > req_row2_col2;
         gt1122_ff <= req_row1_col1 > req_row2_col2;
         m21_ff    <= (W+1)'(req_row2_col1) - (W+1)'(req_row1_col2);
         m02_ff    <= (W+1)'(req_row0_col2) - (W+1)'(req_row2_col0);
         m10_ff    <= (W+1)'(req_row1_col0) - (W+1)'(req_row0_col1);
         p01_ff    <= (W+1)'(req_row0_col1) + (W+1)'(req_row1_col0);
         p02_ff    <= (W+1)'(req_row0_col2) + (W+1)'(req_row2_col0);
         p12_ff    <= (W+1)'(req_row1_col2) + (W+1)'(req_row2_col1);
      end
   end

   // stage 2: pivot choice, radicand, operand selection
   pivot_type             pc_in;
   logic signed [W-1:0]   diag_sel;
   logic signed [RSW-1:0] base;
   logic signed [RSW-1:0] rad;
   logic [RUW-1:0]        rad_u;
   logic [VEW-1:0]        sq_val_in;
   logic signed [W:0]     d0_in, d1_in, d2_in;

   always_comb begin
      priority if (tr_ff > 0) begin
         pc_in = PIVOT_W;
      end else if (gt0011_ff && gt0022_ff) begin
         pc_in = PIVOT_X;
      end else if (gt1122_ff) begin
         pc_in = PIVOT_Y;
      end else begin
         pc_in = PIVOT_Z;
      end
      unique case (pc_in)
         PIVOT_W: begin
            diag_sel = a00_ff;
            d0_in = m21_ff; d1_in = m02_ff; d2_in = m10_ff;
         end
         PIVOT_X: begin
            diag_sel = a00_ff;
            d0_in = m21_ff; d1_in = p01_ff; d2_in = p02_ff;
         end
         PIVOT_Y: begin
            diag_sel = a11_ff;
            d0_in = m02_ff; d1_in = p01_ff; d2_in = p12_ff;
         end
         PIVOT_Z: begin
            diag_sel = a22_ff;
            d0_in = m10_ff; d1_in = p02_ff; d2_in = p12_ff;
         end
         default: begin
            diag_sel = a00_ff;
            d0_in = m21_ff; d1_in = m02_ff; d2_in = m10_ff;
         end
      endcase
      if (pc_in == PIVOT_W) begin
         base = RSW'(tr_ff);
      end else begin
         base = (RSW'(diag_sel) <<< 1) - RSW'(tr_ff);
      end
      rad = ONE + base;
      if (rad[RSW-1] || rad == '0) begin
         rad_u = RUW'(1);
      end else begin
         rad_u = rad[RUW-1:0];
      end
      sq_val_in = VEW'(rad_u) << F;
   end

   logic                v2_ff;
   logic [VEW-1:0]      sq_val_ff;
   pivot_type           pc2_ff;
   logic signed [W:0]   d0_ff, d1_ff, d2_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
      end else if (advance) begin
         v2_ff <= v1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         sq_val_ff <= sq_val_in;
         pc2_ff    <= pc_in;
         d0_ff     <= d0_in;
         d1_ff     <= d1_in;
         d2_ff     <= d2_in;
      end
   end

   // square root
   pipe_ctl_type   sq_ctl;
   logic           sq_valid;
   logic [QW-1:0]  sq_root;
   logic [SQS-1:0] sq_side;

   assign sq_ctl.advance = advance;
   assign sq_ctl.valid   = v2_ff;

   rmq_sqrt_pipe #(
      .VALUE_WIDTH (VEW),
      .SIDE_WIDTH  (SQS)
   ) u_sqrt (
      .clock     (clock),
      .reset     (reset),
      .ctl_in    (sq_ctl),
      .value     (sq_val_ff),
      .side_in   ({pc2_ff, d0_ff, d1_ff, d2_ff}),
      .valid_out (sq_valid),
      .root      (sq_root),
      .side_out  (sq_side)
   );

   // stage 3: magnitudes, rounding offset, pivot component
   pivot_type          sq_pc;
   logic signed [W:0]  sd0, sd1, sd2;
   logic [W:0]         mag0, mag1, mag2;
   logic [QW:0]        piv_sum;

   always_comb begin
      sq_pc   = pivot_type'(sq_side[SQS-1 -: PIVOT_WIDTH]);
      sd0     = sq_side[3*(W+1)-1 -: W+1];
      sd1     = sq_side[2*(W+1)-1 -: W+1];
      sd2     = sq_side[W:0];
      mag0    = sd0[W] ? (~sd0 + (W+1)'(1)) : sd0;
      mag1    = sd1[W] ? (~sd1 + (W+1)'(1)) : sd1;
      mag2    = sd2[W] ? (~sd2 + (W+1)'(1)) : sd2;
      piv_sum = (QW+1)'(sq_root) + (QW+1)'(1);
   end

   logic            v3_ff;
   logic [NW-1:0]   n0_ff, n1_ff, n2_ff;
   logic [DW-1:0]   s_ff;
   logic [QW-1:0]   piv_ff;
   logic            neg0_ff, neg1_ff, neg2_ff;
   pivot_type       pc3_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v3_ff <= 1'b0;
      end else if (advance) begin
         v3_ff <= sq_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         n0_ff   <= (NW'(mag0) << F) + NW'(sq_root);
         n1_ff   <= (NW'(mag1) << F) + NW'(sq_root);
         n2_ff   <= (NW'(mag2) << F) + NW'(sq_root);
         s_ff    <= {sq_root, 1'b0};
         piv_ff  <= piv_sum[QW:1];
         neg0_ff <= sd0[W];
         neg1_ff <= sd1[W];
         neg2_ff <= sd2[W];
         pc3_ff  <= sq_pc;
      end
   end

   // three dividers in lockstep
   pipe_ctl_type   dv_ctl;
   logic           dv0_valid, dv1_valid, dv2_valid;
   logic [NW-1:0]  q0, q1, q2;
   logic [D0S-1:0] dv0_side;
   logic           dv1_neg, dv2_neg;

   assign dv_ctl.advance = advance;
   assign dv_ctl.valid   = v3_ff;

   rmq_div_pipe #(
      .DIVIDEND_WIDTH (NW),
      .DIVISOR_WIDTH  (DW),
      .SIDE_WIDTH     (D0S)
   ) u_div0 (
      .clock     (clock),
      .reset     (reset),
      .ctl_in    (dv_ctl),
      .dividend  (n0_ff),
      .divisor   (s_ff),
      .side_in   ({pc3_ff, piv_ff, neg0_ff}),
      .valid_out (dv0_valid),
      .quotient  (q0),
      .side_out  (dv0_side)
   );

   rmq_div_pipe #(
      .DIVIDEND_WIDTH (NW),
      .DIVISOR_WIDTH  (DW),
      .SIDE_WIDTH     (1)
   ) u_div1 (
      .clock     (clock),
      .reset     (reset),
      .ctl_in    (dv_ctl),
      .dividend  (n1_ff),
      .divisor   (s_ff),
      .side_in   (neg1_ff),
      .valid_out (dv1_valid),
      .quotient  (q1),
      .side_out  (dv1_neg)
   );

   rmq_div_pipe #(
      .DIVIDEND_WIDTH (NW),
      .DIVISOR_WIDTH  (DW),
      .SIDE_WIDTH     (1)
   ) u_div2 (
      .clock     (clock),
      .reset     (reset),
      .ctl_in    (dv_ctl),
      .dividend  (n2_ff),
      .divisor   (s_ff),
      .side_in   (neg2_ff),
      .valid_out (dv2_valid),
      .quotient  (q2),
      .side_out  (dv2_neg)
   );

   // output stage: saturation and slot placement
   pivot_type     out_pc;
   logic [QW-1:0] out_piv;
   logic [W:0]    cq0, cq1, cq2, cpv;
   logic [W:0]    w_in, x_in, y_in, z_in;

   always_comb begin
      out_pc  = pivot_type'(dv0_side[D0S-1 -: PIVOT_WIDTH]);
      out_piv = dv0_side[QW:1];
      cq0     = clamp_q(q0, dv0_side[0]);
      cq1     = clamp_q(q1, dv1_neg);
      cq2     = clamp_q(q2, dv2_neg);
      cpv     = clamp_q(NW'(out_piv), 1'b0);
      unique case (out_pc)
         PIVOT_W: begin w_in = cpv; x_in = cq0; y_in = cq1; z_in = cq2; end
         PIVOT_X: begin w_in = cq0; x_in = cpv; y_in = cq1; z_in = cq2; end
         PIVOT_Y: begin w_in = cq0; x_in = cq1; y_in = cpv; z_in = cq2; end
         PIVOT_Z: begin w_in = cq0; x_in = cq1; y_in = cq2; z_in = cpv; end
         default: begin w_in = cpv; x_in = cq0; y_in = cq1; z_in = cq2; end
      endcase
   end

   logic                rsp_valid_ff;
   logic signed [W-1:0] quat_w_ff, quat_x_ff, quat_y_ff, quat_z_ff;
   pivot_type           pivot_ff;
   logic                sat_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= dv0_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         quat_w_ff <= w_in[W-1:0];
         quat_x_ff <= x_in[W-1:0];
         quat_y_ff <= y_in[W-1:0];
         quat_z_ff <= z_in[W-1:0];
         pivot_ff  <= out_pc;
         sat_ff    <= w_in[W] | x_in[W] | y_in[W] | z_in[W];
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_quat_w     = quat_w_ff;
   assign rsp_quat_x     = quat_x_ff;
   assign rsp_quat_y     = quat_y_ff;
   assign rsp_quat_z     = quat_z_ff;
   assign rsp_pivot_case = pivot_ff;
   assign rsp_saturated  = sat_ff;

`ifndef SYNTHESIS
   // the three dividers must stay in step: their output valid bits must agree
   assert property (@(posedge clock) disable iff (reset)
      (dv0_valid == dv1_valid) && (dv0_valid == dv2_valid))
      else $error("divider pipes out of step");

   // the pivot component is S/4 with S >= 2, so it is positive unless clamped
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_saturated) |->
         ((rsp_pivot_case == PIVOT_W && rsp_quat_w > 0) ||
          (rsp_pivot_case == PIVOT_X && rsp_quat_x > 0) ||
          (rsp_pivot_case == PIVOT_Y && rsp_quat_y > 0) ||
          (rsp_pivot_case == PIVOT_Z && rsp_quat_z > 0)))
      else $error("pivot component not positive");

   // a stalled result holds the whole pipe, including the pivot code
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(pivot_ff) && $stable(sat_ff)))
      else $error("result changed while stalled");
`endif

endmodule

@@ rtl/rmq_sqrt_pipe.sv @@
// ----------------------------------------------------------------------------
// rmq_sqrt_pipe
// integer square root, one root digit per register stage, with sideband
// ----------------------------------------------------------------------------
module rmq_sqrt_pipe #(
   parameter int VALUE_WIDTH = 34,
   parameter int SIDE_WIDTH  = 1,
   localparam int ROOT_WIDTH = VALUE_WIDTH / 2
) (
   input  logic                     clock,
   input  logic                     reset,
   input  rmq_pkg::pipe_ctl_type    ctl_in,
   input  logic [VALUE_WIDTH-1:0]   value,
   input  logic [SIDE_WIDTH-1:0]    side_in,
   output logic                     valid_out,
   output logic [ROOT_WIDTH-1:0]    root,
   output logic [SIDE_WIDTH-1:0]    side_out
);
   import rmq_pkg::*;

   localparam int QW  = ROOT_WIDTH;
   localparam int RWI = QW + 3;

   logic [QW-1:0]          q_ff   [QW];
   logic [RWI-1:0]         r_ff   [QW];
   logic [VALUE_WIDTH-1:0] v_ff   [QW];
   logic [SIDE_WIDTH-1:0]  sd_ff  [QW];
   logic                   vld_ff [QW];

   for (genvar i = 0; i < QW; i++) begin : g_stage
      logic [QW-1:0]          q_prev;
      logic [RWI-1:0]         r_prev;
      logic [VALUE_WIDTH-1:0] v_prev;
      logic [SIDE_WIDTH-1:0]  sd_prev;
      logic                   vld_prev;
      logic [RWI-1:0]         r_sh;
      logic [RWI-1:0]         trial;
      logic [QW-1:0]          q_in;
      logic [RWI-1:0]         r_in;

      if (i == 0) begin : g_first
         assign q_prev   = '0;
         assign r_prev   = '0;
         assign v_prev   = value;
         assign sd_prev  = side_in;
         assign vld_prev = ctl_in.valid;
      end else begin : g_next
         assign q_prev   = q_ff[i-1];
         assign r_prev   = r_ff[i-1];
         assign v_prev   = v_ff[i-1];
         assign sd_prev  = sd_ff[i-1];
         assign vld_prev = vld_ff[i-1];
      end

      always_comb begin
         r_sh  = {r_prev[RWI-3:0], v_prev[VALUE_WIDTH-1 -: 2]};
         trial = {1'b0, q_prev, 2'b01};
         if (r_sh >= trial) begin
            r_in = r_sh - trial;
            q_in = {q_prev[QW-2:0], 1'b1};
         end else begin
            r_in = r_sh;
            q_in = {q_prev[QW-2:0], 1'b0};
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[i] <= 1'b0;
         end else if (ctl_in.advance) begin
            vld_ff[i] <= vld_prev;
         end
      end

      always_ff @(posedge clock) begin
         if (ctl_in.advance) begin
            q_ff[i]  <= q_in;
            r_ff[i]  <= r_in;
            v_ff[i]  <= {v_prev[VALUE_WIDTH-3:0], 2'b00};
            sd_ff[i] <= sd_prev;
         end
      end
   end

   assign valid_out = vld_ff[QW-1];
   assign root      = q_ff[QW-1];
   assign side_out  = sd_ff[QW-1];

endmodule

@@ rtl/rmq_div_pipe.sv @@
// ----------------------------------------------------------------------------
// rmq_div_pipe
// unsigned restoring divider, one quotient bit per register stage
// ----------------------------------------------------------------------------
module rmq_div_pipe #(
   parameter int DIVIDEND_WIDTH = 32,
   parameter int DIVISOR_WIDTH  = 18,
   parameter int SIDE_WIDTH     = 1
) (
   input  logic                        clock,
   input  logic                        reset,
   input  rmq_pkg::pipe_ctl_type       ctl_in,
   input  logic [DIVIDEND_WIDTH-1:0]   dividend,
   input  logic [DIVISOR_WIDTH-1:0]    divisor,
   input  logic [SIDE_WIDTH-1:0]       side_in,
   output logic                        valid_out,
   output logic [DIVIDEND_WIDTH-1:0]   quotient,
   output logic [SIDE_WIDTH-1:0]       side_out
);
   import rmq_pkg::*;

   localparam int NW = DIVIDEND_WIDTH;
   localparam int DW = DIVISOR_WIDTH;

   logic [NW-1:0]         q_ff   [NW];
   logic [DW-1:0]         rem_ff [NW];
   logic [NW-1:0]         n_ff   [NW];
   logic [DW-1:0]         d_ff   [NW];
   logic [SIDE_WIDTH-1:0] sd_ff  [NW];
   logic                  vld_ff [NW];

   for (genvar i = 0; i < NW; i++) begin : g_stage
      logic [NW-1:0]         q_prev;
      logic [DW-1:0]         rem_prev;
      logic [NW-1:0]         n_prev;
      logic [DW-1:0]         d_prev;
      logic [SIDE_WIDTH-1:0] sd_prev;
      logic                  vld_prev;
      logic [DW:0]           rem_sh;
      logic [DW:0]           diff;
      logic [NW-1:0]         q_in;
      logic [DW-1:0]         rem_in;

      if (i == 0) begin : g_first
         assign q_prev   = '0;
         assign rem_prev = '0;
         assign n_prev   = dividend;
         assign d_prev   = divisor;
         assign sd_prev  = side_in;
         assign vld_prev = ctl_in.valid;
      end else begin : g_next
         assign q_prev   = q_ff[i-1];
         assign rem_prev = rem_ff[i-1];
         assign n_prev   = n_ff[i-1];
         assign d_prev   = d_ff[i-1];
         assign sd_prev  = sd_ff[i-1];
         assign vld_prev = vld_ff[i-1];
      end

      always_comb begin
         rem_sh = {rem_prev, n_prev[NW-1]};
         diff   = rem_sh - {1'b0, d_prev};
         if (rem_sh >= {1'b0, d_prev}) begin
            rem_in = diff[DW-1:0];
            q_in   = {q_prev[NW-2:0], 1'b1};
         end else begin
            rem_in = rem_sh[DW-1:0];
            q_in   = {q_prev[NW-2:0], 1'b0};
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[i] <= 1'b0;
         end else if (ctl_in.advance) begin
            vld_ff[i] <= vld_prev;
         end
      end

      always_ff @(posedge clock) begin
         if (ctl_in.advance) begin
            q_ff[i]   <= q_in;
            rem_ff[i] <= rem_in;
            n_ff[i]   <= {n_prev[NW-2:0], 1'b0};
            d_ff[i]   <= d_prev;
            sd_ff[i]  <= sd_prev;
         end
      end
   end

   assign valid_out = vld_ff[NW-1];
   assign quotient  = q_ff[NW-1];
   assign side_out  = sd_ff[NW-1];

endmodule

@@ tb/rotation_matrix_to_quaternion_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// rotation_matrix_to_quaternion_tb
// drives matrices through the pivot-selecting quaternion pipeline and checks
// every quaternion, pivot and saturation flag against a fixed-point predictor
// ----------------------------------------------------------------------------
module rotation_matrix_to_quaternion_tb;
   import rmq_pkg::*;

   localparam int EW = 16;
   localparam int FB = 14;
   localparam int LATENCY = 52;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam logic signed [EW-1:0] ONE_Q = 16'sd16384;

   typedef logic signed [EW-1:0] elem_type;
   typedef struct {
      elem_type m[9];
   } matrix_type;
   typedef struct {
      elem_type w, x, y, z;
      pivot_type pivot;
      logic sat;
   } quat_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   elem_type req_m[9] = '{default: '0};
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   elem_type rsp_quat_w, rsp_quat_x, rsp_quat_y, rsp_quat_z;
   pivot_type rsp_pivot_case;
   logic rsp_saturated;

   quat_type expected_quats[$];
   int errors = 0;
   int matrices_sent = 0;
   int quats_seen = 0;
   int idle_cycles = 0;
   bit stall_enable = 1'b1;
   bit gap_enable = 1'b1;
   int pivot_hits[4];
   int sat_hits = 0;

   rotation_matrix_to_quaternion u_top (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall),
      .req_row0_col0(req_m[0]), .req_row0_col1(req_m[1]), .req_row0_col2(req_m[2]),
      .req_row1_col0(req_m[3]), .req_row1_col1(req_m[4]), .req_row1_col2(req_m[5]),
      .req_row2_col0(req_m[6]), .req_row2_col1(req_m[7]), .req_row2_col2(req_m[8]),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_quat_w(rsp_quat_w), .rsp_quat_x(rsp_quat_x),
      .rsp_quat_y(rsp_quat_y), .rsp_quat_z(rsp_quat_z),
      .rsp_pivot_case(rsp_pivot_case), .rsp_saturated(rsp_saturated)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   function automatic longint isqrt(longint v);
      longint r;
      r = 0;
      for (int b = 31; b >= 0; b--) begin
         if ((r + (64'sd1 <<< b)) * (r + (64'sd1 <<< b)) <= v) r = r + (64'sd1 <<< b);
      end
      return r;
   endfunction

   function automatic longint quotient_rounded(longint d, longint s);
      longint mag, q;
      mag = (d < 0) ? -d : d;
      q = ((mag <<< FB) + (s >>> 1)) / s;
      return (d < 0) ? -q : q;
   endfunction

   function automatic elem_type clamp(longint v, ref logic sat);
      if (v > 32767) begin
         sat = 1'b1;
         return 16'sh7fff;
      end
      if (v < -32768) begin
         sat = 1'b1;
         return 16'sh8000;
      end
      return elem_type'(v);
   endfunction

   function automatic quat_type quat_from_matrix(matrix_type mx);
      longint a[9];
      longint tr, rad, root, s, piv;
      longint c[4];
      quat_type q;
      logic sat;
      for (int i = 0; i < 9; i++) a[i] = longint'(mx.m[i]);
      tr = a[0] + a[4] + a[8];
      if (tr > 0) begin
         q.pivot = PIVOT_W;
         rad = longint'(ONE_Q) + tr;
      end else if (a[0] > a[4] && a[0] > a[8]) begin
         q.pivot = PIVOT_X;
         rad = longint'(ONE_Q) + a[0] - a[4] - a[8];
      end else if (a[4] > a[8]) begin
         q.pivot = PIVOT_Y;
         rad = longint'(ONE_Q) + a[4] - a[0] - a[8];
      end else begin
         q.pivot = PIVOT_Z;
         rad = longint'(ONE_Q) + a[8] - a[0] - a[4];
      end
      if (rad < 1) rad = 1;
      root = isqrt(rad <<< FB);
      s = 2 * root;
      if (s < 1) s = 1;
      piv = (root + 1) >>> 1;
      case (q.pivot)
         PIVOT_W: begin
            c[0] = piv;
            c[1] = quotient_rounded(a[7] - a[5], s);
            c[2] = quotient_rounded(a[2] - a[6], s);
            c[3] = quotient_rounded(a[3] - a[1], s);
         end
         PIVOT_X: begin
            c[0] = quotient_rounded(a[7] - a[5], s);
            c[1] = piv;
            c[2] = quotient_rounded(a[1] + a[3], s);
            c[3] = quotient_rounded(a[2] + a[6], s);
         end
         PIVOT_Y: begin
            c[0] = quotient_rounded(a[2] - a[6], s);
            c[1] = quotient_rounded(a[1] + a[3], s);
            c[2] = piv;
            c[3] = quotient_rounded(a[5] + a[7], s);
         end
         default: begin
            c[0] = quotient_rounded(a[3] - a[1], s);
            c[1] = quotient_rounded(a[2] + a[6], s);
            c[2] = quotient_rounded(a[5] + a[7], s);
            c[3] = piv;
         end
      endcase
      sat = 1'b0;
      q.w = clamp(c[0], sat);
      q.x = clamp(c[1], sat);
      q.y = clamp(c[2], sat);
      q.z = clamp(c[3], sat);
      q.sat = sat;
      return q;
   endfunction

   task automatic send_matrix(matrix_type mx);
      if (gap_enable && $urandom_range(0, 5) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 3)) @(negedge clock);
      end
      for (int i = 0; i < 9; i++) req_m[i] <= mx.m[i];
      req_valid <= 1'b1;
      do @(posedge clock); while (req_stall);
      expected_quats.push_back(quat_from_matrix(mx));
      matrices_sent++;
      @(negedge clock);
   endtask

   // result stall bursts
   initial begin
      forever begin
         @(negedge clock);
         if (stall_enable && $urandom_range(0, 5) == 0) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 3)) @(negedge clock);
         end
         rsp_stall <= 1'b0;
      end
   end

   // result checker and watchdog
   always @(posedge clock) begin
      quat_type e;
      if (!reset) begin
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) idle_cycles <= 0;
         else idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: watchdog expired, %0d results outstanding", $time,
                     expected_quats.size());
            $display("Test completed with failures");
            $finish;
         end
      end
      if (!reset && rsp_valid && !rsp_stall) begin
         quats_seen++;
         if (expected_quats.size() == 0) begin
            $display("%0t: unexpected result w=%0d x=%0d y=%0d z=%0d", $time,
                     rsp_quat_w, rsp_quat_x, rsp_quat_y, rsp_quat_z);
            errors++;
         end else begin
            e = expected_quats.pop_front();
            pivot_hits[e.pivot]++;
            if (e.sat) sat_hits++;
            if (rsp_quat_w !== e.w || rsp_quat_x !== e.x || rsp_quat_y !== e.y ||
                rsp_quat_z !== e.z || rsp_pivot_case !== e.pivot ||
                rsp_saturated !== e.sat) begin
               $display("%0t: mismatch expected w=%0d x=%0d y=%0d z=%0d pivot=%0d sat=%0b",
                        $time, e.w, e.x, e.y, e.z, e.pivot, e.sat);
               $display("%0t:          actual   w=%0d x=%0d y=%0d z=%0d pivot=%0d sat=%0b",
                        $time, rsp_quat_w, rsp_quat_x, rsp_quat_y, rsp_quat_z,
                        rsp_pivot_case, rsp_saturated);
               errors++;
            end
         end
      end
   end

   function automatic matrix_type diag_matrix(elem_type d0, elem_type d1, elem_type d2,
                                              elem_type off);
      matrix_type mx;
      for (int i = 0; i < 9; i++) mx.m[i] = off;
      mx.m[0] = d0;
      mx.m[4] = d1;
      mx.m[8] = d2;
      return mx;
   endfunction

   function automatic elem_type rand_elem();
      return elem_type'($urandom_range(0, 65535));
   endfunction

   // rough rotation: all terms in [-8192, 8192], then unless big is 3 one diagonal term in [8192, 16384]
   function automatic matrix_type near_rotation();
      matrix_type mx;
      int big;
      for (int i = 0; i < 9; i++)
         mx.m[i] = elem_type'($signed($urandom_range(0, 16384)) - 8192);
      big = $urandom_range(0, 3);
      if (big < 3) mx.m[big * 4] = elem_type'($urandom_range(8192, 16384));
      return mx;
   endfunction

   task automatic test_directed();
      matrix_type mx;
      send_matrix(diag_matrix(ONE_Q, ONE_Q, ONE_Q, 16'sd0));
      send_matrix(diag_matrix(ONE_Q, -ONE_Q, -ONE_Q, 16'sd0));
      send_matrix(diag_matrix(-ONE_Q, ONE_Q, -ONE_Q, 16'sd0));
      send_matrix(diag_matrix(-ONE_Q, -ONE_Q, ONE_Q, 16'sd0));
      // ties in the diagonal fall through to later pivots
      send_matrix(diag_matrix(16'sd0, 16'sd0, 16'sd0, 16'sd100));
      send_matrix(diag_matrix(-16'sd100, -16'sd100, -16'sd200, 16'sd0));
      send_matrix(diag_matrix(-16'sd100, -16'sd200, -16'sd200, 16'sd0));
      send_matrix(diag_matrix(16'sd1, -16'sd1, 16'sd0, 16'sd0));
      send_matrix(diag_matrix(16'sd1, 16'sd0, 16'sd0, 16'sd0));
      // extremes and saturation
      send_matrix(diag_matrix(16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff));
      send_matrix(diag_matrix(16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000));
      send_matrix(diag_matrix(16'sh8000, 16'sh8000, 16'sh8000, 16'sh7fff));
      send_matrix(diag_matrix(16'sh7fff, 16'sh8000, 16'sh8000, 16'sh8000));
      send_matrix(diag_matrix(16'sh8000, 16'sh8000, 16'sh7fff, 16'sh7fff));
      send_matrix(diag_matrix(16'sh8000, 16'sh7fff, 16'sh8000, 16'sh8000));
      for (int k = 0; k < 4; k++) begin
         for (int i = 0; i < 9; i++) mx.m[i] = (k[0] ^ i[0]) ? 16'sh7fff : 16'sh8000;
         if (k[1]) for (int i = 0; i < 9; i++) mx.m[i] = ~mx.m[i];
         send_matrix(mx);
      end
      for (int i = 0; i < 9; i++) mx.m[i] = 16'sh5555;
      send_matrix(mx);
      for (int i = 0; i < 9; i++) mx.m[i] = 16'shaaaa;
      send_matrix(mx);
   endtask

   task automatic test_random(int count);
      matrix_type mx;
      for (int n = 0; n < count; n++) begin
         if ($urandom_range(0, 3) == 0)
            for (int i = 0; i < 9; i++) mx.m[i] = rand_elem();
         else
            mx = near_rotation();
         send_matrix(mx);
      end
   endtask

   task automatic test_back_to_back(int count);
      gap_enable = 1'b0;
      stall_enable = 1'b0;
      test_random(count);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (expected_quats.size() != 0) @(posedge clock);
      repeat (LATENCY + 10) @(posedge clock);
   endtask

   initial begin
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_directed();
      test_random(1200);
      test_back_to_back(200);
      drain();
      $display("sent %0d matrices, checked %0d quaternions, %0d saturated", matrices_sent,
               quats_seen, sat_hits);
      $display("pivots w/x/y/z: %0d/%0d/%0d/%0d", pivot_hits[0], pivot_hits[1],
               pivot_hits[2], pivot_hits[3]);
      if (errors == 0 && expected_quats.size() == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule

@@ files.f @@
rtl/rmq_pkg.sv
rtl/rmq_sqrt_pipe.sv
rtl/rmq_div_pipe.sv
rtl/rotation_matrix_to_quaternion.sv
tb/rotation_matrix_to_quaternion_tb.sv
